// File: hdl/frame_slot_ring_manager_unit_macros.svh
// assertion macros for the frame slot ring manager checker
`ifndef FRAME_SLOT_RING_MANAGER_UNIT_MACROS_SVH
`define FRAME_SLOT_RING_MANAGER_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define FSRM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define FSRM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/fsrm_pkg.sv
// shared types and constants of the frame slot ring manager
package fsrm_pkg;

	localparam int MAX_RING_SLOTS = 8;
	localparam int SLOT_W = 3;
	localparam int RING_W = 4;
	localparam int TIME_W = 64;
	localparam int LIMIT_W = 40;

	localparam logic [RING_W-1:0] SLOT_COUNT_RESET = 4'd4;
	localparam logic [LIMIT_W-1:0] STALL_RESET = 40'd1000000000;

	localparam logic REG_SLOT_COUNT = 1'b0;
	localparam logic REG_STALL_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		PH_FREE = 2'd0,
		PH_RAW  = 2'd1,
		PH_BUSY = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		REQ_CAPTURE = 2'd0,
		REQ_CLAIM   = 2'd1,
		REQ_DONE    = 2'd2,
		REQ_PASS    = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_CAPTURED    = 4'd0,
		ST_DROPPED     = 4'd1,
		ST_GRANTED     = 4'd2,
		ST_NONE_READY  = 4'd3,
		ST_DONE_OK     = 4'd4,
		ST_DONE_STALE  = 4'd5,
		ST_SERIALIZE   = 4'd6,
		ST_STALL_FREED = 4'd7,
		ST_PASS_IDLE   = 4'd8
	} status_t;

	// event context shared by all cells while one transaction is in flight
	typedef struct packed {
		req_t               req;
		logic [SLOT_W-1:0]  idx;
		logic [SLOT_W-1:0]  ptr;
		logic [RING_W-1:0]  n;
		logic [TIME_W-1:0]  now;
		logic [LIMIT_W-1:0] limit;
	} ctx_t;

	// token walking the chain, carrying the result not yet sent
	typedef struct packed {
		logic              active;
		logic              pend_v;
		status_t           pend_status;
		logic [SLOT_W-1:0] pend_slot;
	} token_t;

	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [SLOT_W-1:0] slot;
	} emit_t;

endpackage

// File: hdl/fsrm_cell.sv
// one slot of the ring: phase, start stamp and a token stage to the next slot
module fsrm_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic [fsrm_pkg::SLOT_W-1:0] slot_id,
	input  fsrm_pkg::ctx_t            ctx,
	input  fsrm_pkg::token_t          tok_in,
	output fsrm_pkg::token_t          tok_out,
	output fsrm_pkg::emit_t           emit
);
	import fsrm_pkg::*;

	phase_t              phase_q;
	phase_t              phase_d;
	logic [TIME_W-1:0]   stamp_q;
	logic                stamp_we;
	token_t              tok_q;
	token_t              tok_d;
	logic                in_ring;
	logic                act;
	logic                prod;
	status_t             prod_status;
	logic [TIME_W-1:0]   age;

	always_comb begin
		in_ring = {1'b0, slot_id} < ctx.n;
		act = tok_in.active && in_ring;
		age = ctx.now - stamp_q;
		prod = 1'b0;
		prod_status = ST_CAPTURED;
		phase_d = phase_q;
		stamp_we = 1'b0;
		case (ctx.req)
			REQ_CAPTURE: begin
				if (slot_id == ctx.ptr) begin
					prod = 1'b1;
					if (phase_q == PH_FREE) begin
						phase_d = PH_RAW;
						stamp_we = 1'b1;
						prod_status = ST_CAPTURED;
					end else begin
						prod_status = ST_DROPPED;
					end
				end
			end
			REQ_CLAIM: begin
				// a pending result means a lower slot was already granted
				if (!tok_in.pend_v && phase_q == PH_RAW) begin
					prod = 1'b1;
					phase_d = PH_BUSY;
					prod_status = ST_GRANTED;
				end
			end
			REQ_DONE: begin
				if (slot_id == ctx.idx && phase_q == PH_BUSY) begin
					prod = 1'b1;
					phase_d = PH_DONE;
					prod_status = ST_DONE_OK;
				end
			end
			REQ_PASS: begin
				if (phase_q == PH_DONE) begin
					prod = 1'b1;
					phase_d = PH_FREE;
					prod_status = ST_SERIALIZE;
				end else if (phase_q == PH_BUSY && age > {24'b0, ctx.limit}) begin
					prod = 1'b1;
					phase_d = PH_FREE;
					prod_status = ST_STALL_FREED;
				end
			end
			default: begin
				prod = 1'b0;
			end
		endcase
		if (!act) begin
			prod = 1'b0;
			phase_d = phase_q;
			stamp_we = 1'b0;
		end

		tok_d = tok_in;
		tok_d.active = act;
		if (prod) begin
			tok_d.pend_v = 1'b1;
			tok_d.pend_status = prod_status;
			tok_d.pend_slot = slot_id;
		end

		// a new result pushes the older pending one out, never the last
		emit.valid = prod && tok_in.pend_v;
		emit.status = tok_in.pend_status;
		emit.slot = tok_in.pend_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FREE;
			tok_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && stamp_we) begin
			stamp_q <= ctx.now;
		end
	end

	assign tok_out = tok_q;

endmodule

// File: hdl/frame_slot_ring_manager_unit.sv
// top level of the frame slot ring manager: event intake, slot chain, result output
//
//  channel  | direction | transaction carries
//  s_axis   | in        | tuser: req_type; tdata: slot_index, now_time
//  m_axis   | out       | tuser: status; tdata: slot_out; tlast: last
//  apb      | in        | slot_count at 0x0, stall_limit at 0x8
//
// one event at a time: it is accepted, walks the slot chain one cell per cycle
// while the output is not stalled, then a tail stage sends the final result.
// a stalled output freezes the whole chain; the next event is taken while the
// last result still waits. reset frees all slots and clears the pointer;
// no stamp clearing is needed.
module frame_slot_ring_manager_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // [2:0] slot_index, [66:3] now_time, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [2:0] slot_out, rest zero
	output logic [3:0]  m_tuser,   // [3:0] status
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import fsrm_pkg::*;

	logic [RING_W-1:0]  slot_count_q;
	logic [LIMIT_W-1:0] stall_limit_q;
	logic [SLOT_W-1:0]  cap_ptr_q;
	logic               busy_q;
	logic               start_q;
	req_t               req_q;
	logic [SLOT_W-1:0]  idx_q;
	logic [SLOT_W-1:0]  ptr_q;
	logic [TIME_W-1:0]  now_q;
	logic               out_v_q;
	status_t            out_status_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic               out_last_q;

	logic [RING_W-1:0]  ring_n;
	logic [SLOT_W-1:0]  last_cell;
	logic [SLOT_W-1:0]  p_eff;
	logic [RING_W-1:0]  p_inc;
	logic [SLOT_W-1:0]  p_next;
	logic               in_acc;
	logic               cfg_wr;
	logic               advance;
	ctx_t               ctx;
	token_t             tok_head;
	token_t             tok_out [MAX_RING_SLOTS];
	emit_t              emit [MAX_RING_SLOTS];
	token_t             tail;
	emit_t              cell_emit;
	logic               any_emit;
	status_t            sel_status;
	logic [SLOT_W-1:0]  sel_slot;
	logic               sel_last;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[3] == REG_STALL_LIMIT) ? {24'b0, stall_limit_q}
		: {60'b0, slot_count_q};

	always_comb begin
		ring_n = slot_count_q;
		if (ring_n < RING_W'(2)) ring_n = RING_W'(2);
		if (ring_n > RING_W'(MAX_RING_SLOTS)) ring_n = RING_W'(MAX_RING_SLOTS);
		last_cell = SLOT_W'(ring_n - RING_W'(1));
		p_eff = ({1'b0, cap_ptr_q} >= ring_n) ? '0 : cap_ptr_q;
		p_inc = {1'b0, p_eff} + RING_W'(1);
		p_next = (p_inc >= ring_n) ? '0 : p_inc[SLOT_W-1:0];
	end

	assign s_tready = !busy_q;
	assign in_acc = s_tvalid && s_tready;
	assign advance = !out_v_q || m_tready;

	assign ctx = '{req: req_q, idx: idx_q, ptr: ptr_q, n: ring_n, now: now_q,
		limit: stall_limit_q};
	assign tok_head = '{active: start_q, pend_v: 1'b0, pend_status: ST_CAPTURED,
		pend_slot: '0};

	for (genvar i = 0; i < MAX_RING_SLOTS; i++) begin : g_cell
		fsrm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.slot_id (SLOT_W'(i)),
			.ctx     (ctx),
			.tok_in  ((i == 0) ? tok_head : tok_out[(i == 0) ? 0 : i - 1]),
			.tok_out (tok_out[i]),
			.emit    (emit[i])
		);
	end

	assign tail = tok_out[last_cell];

	always_comb begin
		cell_emit = '0;
		for (int i = 0; i < MAX_RING_SLOTS; i++) begin
			if (emit[i].valid) cell_emit = emit[i];
		end
		any_emit = cell_emit.valid || tail.active;
		sel_status = cell_emit.status;
		sel_slot = cell_emit.slot;
		sel_last = 1'b0;
		if (tail.active) begin
			sel_last = 1'b1;
			if (tail.pend_v) begin
				sel_status = tail.pend_status;
				sel_slot = tail.pend_slot;
			end else begin
				// nothing came out of the walk
				case (req_q)
					REQ_CLAIM: begin
						sel_status = ST_NONE_READY;
						sel_slot = '0;
					end
					REQ_DONE: begin
						sel_status = ST_DONE_STALE;
						sel_slot = idx_q;
					end
					default: begin
						sel_status = ST_PASS_IDLE;
						sel_slot = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RESET;
			stall_limit_q <= STALL_RESET;
			cap_ptr_q <= '0;
			busy_q <= 1'b0;
			start_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[3] == REG_SLOT_COUNT) slot_count_q <= pwdata[RING_W-1:0];
				else stall_limit_q <= pwdata[LIMIT_W-1:0];
			end
			if (in_acc) begin
				busy_q <= 1'b1;
				start_q <= 1'b1;
				if (req_t'(s_tuser[1:0]) == REQ_CAPTURE) cap_ptr_q <= p_next;
			end else begin
				if (advance) start_q <= 1'b0;
				if (advance && tail.active) busy_q <= 1'b0;
			end
			if (advance) out_v_q <= any_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q <= req_t'(s_tuser[1:0]);
			idx_q <= s_tdata[2:0];
			now_q <= s_tdata[66:3];
			ptr_q <= p_eff;
		end
		if (advance && any_emit) begin
			out_status_q <= sel_status;
			out_slot_q <= sel_slot;
			out_last_q <= sel_last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser = out_status_q;
	assign m_tdata = {5'b0, out_slot_q};
	assign m_tlast = out_last_q;

endmodule

// File: hdl/fsrm_checker.sv
// port-level checker of the frame slot ring manager, bound to the top level
`include "frame_slot_ring_manager_unit_macros.svh"

module fsrm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);
	import fsrm_pkg::*;

	logic multi_status;
	assign multi_status = (m_tuser == ST_SERIALIZE) || (m_tuser == ST_STALL_FREED);

	// a stalled result stays offered
	`FSRM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tuser), "result lost")
	// one event in flight: intake closes right after a transaction
	`FSRM_ASSERT_NXT(a_one_event, s_tvalid && s_tready, !s_tready, "event taken while busy")
	// only pass results may be followed by more results of the same event
	`FSRM_ASSERT_IMP(a_single_last, m_tvalid && !multi_status, m_tlast, "single result not last")
	// a result not marked last is always a pass result
	`FSRM_ASSERT_IMP(a_nonlast_pass, m_tvalid && !m_tlast, multi_status, "bad non-final result")

endmodule

bind frame_slot_ring_manager_unit fsrm_checker u_fsrm_checker (.*);
